@@ rtl/core/afcpm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// afcpm_pkg: shared types, constants and the multiply program
// Types, register file layout and the micro-program for the affine cell
// point map.
// ----------------------------------------------------------------------------
package afcpm_pkg;

  localparam int CW       = 32;    // coordinate width, signed Q16.16
  localparam int VSLOTS   = 8;     // vertex store depth
  localparam int SLOT_W   = 3;
  localparam int WW       = 128;   // wide datapath width
  localparam int RF_DEPTH = 31;
  localparam int RF_AW    = 5;
  localparam int PC_W     = 6;
  localparam int NB_W     = CW + 1; // narrow multiplier operand width
  localparam int QB       = 33;     // quotient bits produced by the divider

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_FWD  = 2'd1;
  localparam logic [1:0] CMD_INV  = 2'd2;
  localparam logic [1:0] CMD_NONE = 2'd3;

  localparam logic [1:0] CFG_SPACE_DIM = 2'd0;
  localparam logic [1:0] CFG_AXIS_0    = 2'd1;
  localparam logic [1:0] CFG_AXIS_1    = 2'd2;
  localparam logic [1:0] CFG_AXIS_2    = 2'd3;

  // register file layout
  localparam int RF_M   = 0;   // Jacobian, row major
  localparam int RF_P   = 9;   // point
  localparam int RF_V0  = 12;  // vertex 0
  localparam int RF_RHS = 15;  // point minus vertex 0
  localparam int RF_A   = 18;  // cofactors
  localparam int RF_DET = 27;
  localparam int RF_RES = 28;  // forward sums or inverse numerators

  localparam logic [PC_W-1:0] PC_FWD_END   = 6'd8;
  localparam logic [PC_W-1:0] PC_INV_START = 6'd9;
  localparam logic [PC_W-1:0] PC_INV_END   = 6'd38;

  localparam logic [WW-1:0] FRAC_ONE = WW'(65536);
  localparam logic signed [WW-1:0] CLIP_HI = WW'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam logic signed [WW-1:0] CLIP_LO = -CLIP_HI - WW'(1);

  typedef logic [RF_AW-1:0] rf_addr_t;
  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [SLOT_W-1:0] vertex_slot;
    coord_t            coord_a;
    coord_t            coord_b;
    coord_t            coord_c;
  } afcpm_in_t;

  typedef struct packed {
    coord_t out_a;
    coord_t out_b;
    coord_t out_c;
    logic   singular;
    logic   saturated;
  } afcpm_out_t;

  typedef struct packed {
    logic [1:0]        space_dim;
    logic [SLOT_W-1:0] axis_vertex_first;
    logic [SLOT_W-1:0] axis_vertex_second;
    logic [SLOT_W-1:0] axis_vertex_third;
  } afcpm_cfg_t;

  typedef struct packed {
    logic              is_load;
    logic              is_inv;
    logic [SLOT_W-1:0] slot;
    coord_t            c0;
    coord_t            c1;
    coord_t            c2;
  } afcpm_job_t;

  typedef struct packed {
    rf_addr_t src_a;   // wide operand
    rf_addr_t src_b;   // narrow operand
    logic     neg;
    logic     first;
    logic     last;
    rf_addr_t dst;
  } afcpm_instr_t;

  function automatic afcpm_instr_t mk(int a, int b, logic neg, logic first, logic last,
                                      int dst);
    afcpm_instr_t i;
    i.src_a = rf_addr_t'(a);
    i.src_b = rf_addr_t'(b);
    i.neg   = neg;
    i.first = first;
    i.last  = last;
    i.dst   = rf_addr_t'(dst);
    return i;
  endfunction

  // multiply-accumulate program: forward sums, then cofactors, det, numerators
  function automatic afcpm_instr_t afcpm_prog(logic [PC_W-1:0] pc);
    afcpm_instr_t i;
    unique case (pc)
      6'd0:  i = mk(RF_M + 0, RF_P + 0, 1'b0, 1'b1, 1'b0, RF_RES + 0);
      6'd1:  i = mk(RF_M + 1, RF_P + 1, 1'b0, 1'b0, 1'b0, RF_RES + 0);
      6'd2:  i = mk(RF_M + 2, RF_P + 2, 1'b0, 1'b0, 1'b1, RF_RES + 0);
      6'd3:  i = mk(RF_M + 3, RF_P + 0, 1'b0, 1'b1, 1'b0, RF_RES + 1);
      6'd4:  i = mk(RF_M + 4, RF_P + 1, 1'b0, 1'b0, 1'b0, RF_RES + 1);
      6'd5:  i = mk(RF_M + 5, RF_P + 2, 1'b0, 1'b0, 1'b1, RF_RES + 1);
      6'd6:  i = mk(RF_M + 6, RF_P + 0, 1'b0, 1'b1, 1'b0, RF_RES + 2);
      6'd7:  i = mk(RF_M + 7, RF_P + 1, 1'b0, 1'b0, 1'b0, RF_RES + 2);
      6'd8:  i = mk(RF_M + 8, RF_P + 2, 1'b0, 1'b0, 1'b1, RF_RES + 2);
      6'd9:  i = mk(RF_M + 4, RF_M + 8, 1'b0, 1'b1, 1'b0, RF_A + 0);
      6'd10: i = mk(RF_M + 5, RF_M + 7, 1'b1, 1'b0, 1'b1, RF_A + 0);
      6'd11: i = mk(RF_M + 2, RF_M + 7, 1'b0, 1'b1, 1'b0, RF_A + 1);
      6'd12: i = mk(RF_M + 1, RF_M + 8, 1'b1, 1'b0, 1'b1, RF_A + 1);
      6'd13: i = mk(RF_M + 1, RF_M + 5, 1'b0, 1'b1, 1'b0, RF_A + 2);
      6'd14: i = mk(RF_M + 2, RF_M + 4, 1'b1, 1'b0, 1'b1, RF_A + 2);
      6'd15: i = mk(RF_M + 5, RF_M + 6, 1'b0, 1'b1, 1'b0, RF_A + 3);
      6'd16: i = mk(RF_M + 3, RF_M + 8, 1'b1, 1'b0, 1'b1, RF_A + 3);
      6'd17: i = mk(RF_M + 0, RF_M + 8, 1'b0, 1'b1, 1'b0, RF_A + 4);
      6'd18: i = mk(RF_M + 2, RF_M + 6, 1'b1, 1'b0, 1'b1, RF_A + 4);
      6'd19: i = mk(RF_M + 2, RF_M + 3, 1'b0, 1'b1, 1'b0, RF_A + 5);
      6'd20: i = mk(RF_M + 0, RF_M + 5, 1'b1, 1'b0, 1'b1, RF_A + 5);
      6'd21: i = mk(RF_M + 3, RF_M + 7, 1'b0, 1'b1, 1'b0, RF_A + 6);
      6'd22: i = mk(RF_M + 4, RF_M + 6, 1'b1, 1'b0, 1'b1, RF_A + 6);
      6'd23: i = mk(RF_M + 1, RF_M + 6, 1'b0, 1'b1, 1'b0, RF_A + 7);
      6'd24: i = mk(RF_M + 0, RF_M + 7, 1'b1, 1'b0, 1'b1, RF_A + 7);
      6'd25: i = mk(RF_M + 0, RF_M + 4, 1'b0, 1'b1, 1'b0, RF_A + 8);
      6'd26: i = mk(RF_M + 1, RF_M + 3, 1'b1, 1'b0, 1'b1, RF_A + 8);
      6'd27: i = mk(RF_A + 0, RF_M + 0, 1'b0, 1'b1, 1'b0, RF_DET);
      6'd28: i = mk(RF_A + 3, RF_M + 1, 1'b0, 1'b0, 1'b0, RF_DET);
      6'd29: i = mk(RF_A + 6, RF_M + 2, 1'b0, 1'b0, 1'b1, RF_DET);
      6'd30: i = mk(RF_A + 0, RF_RHS + 0, 1'b0, 1'b1, 1'b0, RF_RES + 0);
      6'd31: i = mk(RF_A + 1, RF_RHS + 1, 1'b0, 1'b0, 1'b0, RF_RES + 0);
      6'd32: i = mk(RF_A + 2, RF_RHS + 2, 1'b0, 1'b0, 1'b1, RF_RES + 0);
      6'd33: i = mk(RF_A + 3, RF_RHS + 0, 1'b0, 1'b1, 1'b0, RF_RES + 1);
      6'd34: i = mk(RF_A + 4, RF_RHS + 1, 1'b0, 1'b0, 1'b0, RF_RES + 1);
      6'd35: i = mk(RF_A + 5, RF_RHS + 2, 1'b0, 1'b0, 1'b1, RF_RES + 1);
      6'd36: i = mk(RF_A + 6, RF_RHS + 0, 1'b0, 1'b1, 1'b0, RF_RES + 2);
      6'd37: i = mk(RF_A + 7, RF_RHS + 1, 1'b0, 1'b0, 1'b0, RF_RES + 2);
      6'd38: i = mk(RF_A + 8, RF_RHS + 2, 1'b0, 1'b0, 1'b1, RF_RES + 2);
      default: i = mk(RF_M, RF_P, 1'b0, 1'b1, 1'b0, RF_RES);
    endcase
    return i;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/afcpm_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// afcpm_front: input stage
// Accepts items, drops unused commands and turns the rest into jobs for the
// back end, held in one register.
// ----------------------------------------------------------------------------
module afcpm_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire afcpm_pkg::afcpm_in_t  in_item,
  output logic                       job_valid,
  input  wire logic                  job_ready,
  output afcpm_pkg::afcpm_job_t      job
);
  import afcpm_pkg::*;

  logic       full;
  logic       take;
  afcpm_job_t cls;

  assign in_ready  = !full || job_ready;
  assign job_valid = full;
  assign take      = in_valid && in_ready;

  // classify the item
  always_comb begin
    cls.is_load = (in_item.cmd == CMD_LOAD);
    cls.is_inv  = (in_item.cmd == CMD_INV);
    cls.slot    = in_item.vertex_slot;
    cls.c0      = in_item.coord_a;
    cls.c1      = in_item.coord_b;
    cls.c2      = in_item.coord_c;
  end

  // hold one job until the queue takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else begin
      if (full && job_ready) full <= 1'b0;
      if (take && in_item.cmd != CMD_NONE) full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) job <= cls;
  end

endmodule
`default_nettype wire

@@ rtl/core/afcpm_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// afcpm_queue: two-entry job queue
// Decouples the input stage from the back end.
// ----------------------------------------------------------------------------
module afcpm_queue (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push_valid,
  output logic                       push_ready,
  input  wire afcpm_pkg::afcpm_job_t push_job,
  output logic                       pop_valid,
  input  wire logic                  pop_ready,
  output afcpm_pkg::afcpm_job_t      pop_job
);
  import afcpm_pkg::*;

  afcpm_job_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_job    = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      if (push && !pop)      count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
  end

endmodule
`default_nettype wire

@@ rtl/core/afcpm_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// afcpm_back: execution engine
// Owns the vertex store, builds the Jacobian in a register file, runs the
// multiply program on one shared 32x33 multiplier, rounds or divides, and
// holds the result in an output register.
// ----------------------------------------------------------------------------
module afcpm_back (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire afcpm_pkg::afcpm_cfg_t cfg,
  input  wire logic                  job_valid,
  output logic                       job_ready,
  input  wire afcpm_pkg::afcpm_job_t job,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output afcpm_pkg::afcpm_out_t      out_item
);
  import afcpm_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0,  S_RD0  = 5'd1,  S_CAP0 = 5'd2,  S_RDK  = 5'd3;
  localparam logic [4:0] S_CAPK = 5'd4,  S_WRM  = 5'd5,  S_WRP  = 5'd6,  S_MRD  = 5'd7;
  localparam logic [4:0] S_MABS = 5'd8,  S_MMUL = 5'd9,  S_MACC = 5'd10, S_FRD  = 5'd11;
  localparam logic [4:0] S_F1   = 5'd12, S_F2   = 5'd13, S_DRD  = 5'd14, S_D1   = 5'd15;
  localparam logic [4:0] S_IRD  = 5'd16, S_I1   = 5'd17, S_I2   = 5'd18, S_I3   = 5'd19;
  localparam logic [4:0] S_IDIV = 5'd20, S_I4   = 5'd21, S_OUT  = 5'd22, S_DONE = 5'd23;

  function automatic logic [WW-1:0] sx(coord_t c);
    return {{(WW-CW){c[CW-1]}}, c};
  endfunction

  logic [4:0]          state;
  logic                is_inv;
  coord_t              pt [3];
  coord_t              v0 [3];
  coord_t              vk [3];
  logic [1:0]          k;
  logic [1:0]          row;
  logic [1:0]          grp;
  logic [PC_W-1:0]     pc;
  logic [1:0]          chunk;
  logic [WW-1:0]       acc;
  logic [WW-1:0]       prod;
  logic [WW-1:0]       mag_a;
  logic [NB_W-1:0]     mag_b;
  logic                psgn;
  logic                fsgn;
  logic [WW-1:0]       fm;
  logic [WW-1:0]       fv0;
  logic [WW-1:0]       val;
  logic                dsgn;
  logic                nsgn;
  logic [WW-1:0]       ad;
  logic [WW-1:0]       num;
  logic [WW-1:0]       rem;
  logic [QB-1:0]       qbits;
  logic [5:0]          dcnt;
  logic                huge;
  coord_t              res [3];
  logic                sat;
  logic                sing;
  afcpm_out_t          out_reg;
  logic                out_reg_valid;

  // register file and vertex store
  logic [WW-1:0]       rf [RF_DEPTH];
  logic                rf_we;
  rf_addr_t            rf_waddr;
  logic [WW-1:0]       rf_wdata;
  rf_addr_t            rd_addr_a;
  rf_addr_t            rd_addr_b;
  logic [WW-1:0]       rd_a;
  logic [WW-1:0]       rd_b;
  logic [3*CW-1:0]     vmem [VSLOTS];
  logic [SLOT_W-1:0]   vm_raddr;
  logic [3*CW-1:0]     vm_rd;

  logic [1:0]          dim;
  afcpm_instr_t        ins;
  logic [WW-1:0]       base;
  logic [WW-1:0]       acc_n;
  logic [2*CW:0]       part;
  logic [WW-1:0]       m_val;
  logic [WW-1:0]       pz;
  logic [WW-1:0]       vz;
  logic [WW-1:0]       dsor;
  logic [WW-1:0]       rem2;
  logic                ge;
  logic signed [WW-1:0] sval;
  coord_t              clipped;
  logic                clip_hit;
  logic                pop;

  assign dim       = (cfg.space_dim == 2'd0) ? 2'd1 : cfg.space_dim;
  assign ins       = afcpm_prog(pc);
  assign job_ready = (state == S_IDLE);
  assign pop       = job_valid && job_ready;
  assign out_valid = out_reg_valid;
  assign out_item  = out_reg;

  // Jacobian entry and point values for the row being written
  always_comb begin
    if (row < dim && k < dim) m_val = sx(vk[row]) - sx(v0[row]);
    else if (row == k)        m_val = FRAC_ONE;
    else                      m_val = '0;
    pz = (row < dim) ? sx(pt[row]) : '0;
    vz = (row < dim) ? sx(v0[row]) : '0;
  end

  // register file write and read addresses
  always_comb begin
    rf_we     = 1'b0;
    rf_waddr  = rf_addr_t'(RF_M);
    rf_wdata  = m_val;
    rd_addr_a = ins.src_a;
    rd_addr_b = ins.src_b;
    base      = ins.first ? '0 : acc;
    acc_n     = psgn ? base - prod : base + prod;
    case (state)
      S_WRM: begin
        rf_we    = 1'b1;
        rf_waddr = rf_addr_t'(RF_M) + rf_addr_t'(row) * rf_addr_t'(3) + rf_addr_t'(k);
      end
      S_WRP: begin
        rf_we = 1'b1;
        case (grp)
          2'd0: begin
            rf_waddr = rf_addr_t'(RF_P) + rf_addr_t'(row);
            rf_wdata = pz;
          end
          2'd1: begin
            rf_waddr = rf_addr_t'(RF_V0) + rf_addr_t'(row);
            rf_wdata = vz;
          end
          default: begin
            rf_waddr = rf_addr_t'(RF_RHS) + rf_addr_t'(row);
            rf_wdata = pz - vz;
          end
        endcase
      end
      S_MACC: begin
        rf_we    = ins.last;
        rf_waddr = ins.dst;
        rf_wdata = acc_n;
      end
      S_FRD: begin
        rd_addr_a = rf_addr_t'(RF_RES) + rf_addr_t'(row);
        rd_addr_b = rf_addr_t'(RF_V0) + rf_addr_t'(row);
      end
      S_DRD: rd_addr_a = rf_addr_t'(RF_DET);
      S_IRD: rd_addr_a = rf_addr_t'(RF_RES) + rf_addr_t'(row);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rf_we) rf[rf_waddr] <= rf_wdata;
    rd_a <= rf[rd_addr_a];
    rd_b <= rf[rd_addr_b];
  end

  // vertex store: loads write, preparation reads vertex 0 and the axes
  always_comb begin
    case (k)
      2'd0:    vm_raddr = cfg.axis_vertex_first;
      2'd1:    vm_raddr = cfg.axis_vertex_second;
      default: vm_raddr = cfg.axis_vertex_third;
    endcase
    if (state == S_RD0) vm_raddr = '0;
  end

  always_ff @(posedge clk) begin
    if (pop && job.is_load) vmem[job.slot] <= {job.c2, job.c1, job.c0};
    vm_rd <= vmem[vm_raddr];
  end

  // shared multiplier and divider step
  assign part = (2*CW+1)'(mag_a[32*chunk +: 32]) * (2*CW+1)'(mag_b);
  assign dsor = ad << 1;
  assign rem2 = {rem[WW-2:0], num[QB-1]};
  assign ge   = (rem2 >= dsor);

  // saturate to the coordinate range
  always_comb begin
    sval     = $signed(val);
    clip_hit = 1'b0;
    clipped  = val[CW-1:0];
    if (sval > CLIP_HI) begin
      clip_hit = 1'b1;
      clipped  = CLIP_HI[CW-1:0];
    end else if (sval < CLIP_LO) begin
      clip_hit = 1'b1;
      clipped  = CLIP_LO[CW-1:0];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (pop && !job.is_load) state <= S_RD0;
        S_RD0:  state <= S_CAP0;
        S_CAP0: state <= S_RDK;
        S_RDK:  state <= S_CAPK;
        S_CAPK: state <= S_WRM;
        S_WRM: begin
          if (row == 2'd2) state <= (k == 2'd2) ? S_WRP : S_RDK;
        end
        S_WRP:  if (grp == 2'd2 && row == 2'd2) state <= S_MRD;
        S_MRD:  state <= S_MABS;
        S_MABS: state <= S_MMUL;
        S_MMUL: if (chunk == 2'd3) state <= S_MACC;
        S_MACC: begin
          if (pc == (is_inv ? PC_INV_END : PC_FWD_END)) state <= is_inv ? S_DRD : S_FRD;
          else                                          state <= S_MRD;
        end
        S_FRD:  state <= S_F1;
        S_F1:   state <= S_F2;
        S_F2:   state <= S_OUT;
        S_DRD:  state <= S_D1;
        S_D1:   state <= (rd_a == '0) ? S_DONE : S_IRD;
        S_IRD:  state <= S_I1;
        S_I1:   state <= S_I2;
        S_I2:   state <= S_I3;
        S_I3:   state <= ((num >> QB) >= dsor) ? S_I4 : S_IDIV;
        S_IDIV: if (dcnt == 6'(QB - 1)) state <= S_I4;
        S_I4:   state <= S_OUT;
        S_OUT: begin
          if (row == 2'd2) state <= S_DONE;
          else             state <= is_inv ? S_IRD : S_FRD;
        end
        S_DONE: if (!out_reg_valid || out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        is_inv <= job.is_inv;
        pt[0]  <= job.c0;
        pt[1]  <= job.c1;
        pt[2]  <= job.c2;
        sat    <= 1'b0;
        sing   <= 1'b0;
        k      <= 2'd0;
        row    <= 2'd0;
        grp    <= 2'd0;
      end
      S_CAP0: begin
        v0[0] <= vm_rd[0 +: CW];
        v0[1] <= vm_rd[CW +: CW];
        v0[2] <= vm_rd[2*CW +: CW];
      end
      S_CAPK: begin
        vk[0] <= vm_rd[0 +: CW];
        vk[1] <= vm_rd[CW +: CW];
        vk[2] <= vm_rd[2*CW +: CW];
        row   <= 2'd0;
      end
      S_WRM: begin
        row <= row + 2'd1;
        if (row == 2'd2) begin
          row <= 2'd0;
          k   <= k + 2'd1;
        end
      end
      S_WRP: begin
        row <= row + 2'd1;
        if (row == 2'd2) begin
          row <= 2'd0;
          grp <= grp + 2'd1;
        end
        pc <= is_inv ? PC_INV_START : '0;
      end
      S_MABS: begin
        mag_a <= rd_a[WW-1] ? -rd_a : rd_a;
        mag_b <= rd_b[NB_W-1] ? -rd_b[NB_W-1:0] : rd_b[NB_W-1:0];
        psgn  <= rd_a[WW-1] ^ rd_b[NB_W-1] ^ ins.neg;
        prod  <= '0;
        chunk <= 2'd0;
      end
      S_MMUL: begin
        prod  <= prod + (WW'(part) << (32 * chunk));
        chunk <= chunk + 2'd1;
      end
      S_MACC: begin
        acc <= acc_n;
        pc  <= pc + PC_W'(1);
        row <= 2'd0;
      end
      S_F1: begin
        fsgn <= rd_a[WW-1];
        fm   <= (rd_a[WW-1] ? ~rd_a : rd_a) + (rd_a[WW-1] ? WW'(32769) : WW'(32768));
        fv0  <= rd_b;
      end
      S_F2: val <= fsgn ? fv0 - (fm >> 16) : fv0 + (fm >> 16);
      S_D1: begin
        dsgn <= rd_a[WW-1];
        ad   <= rd_a[WW-1] ? -rd_a : rd_a;
        if (rd_a == '0) begin
          sing   <= 1'b1;
          res[0] <= '0;
          res[1] <= '0;
          res[2] <= '0;
        end
      end
      S_I1: begin
        nsgn <= rd_a[WW-1];
        num  <= rd_a[WW-1] ? -rd_a : rd_a;
      end
      S_I2: num <= (num << 17) + ad;
      S_I3: begin
        huge  <= ((num >> QB) >= dsor);
        rem   <= num >> QB;
        qbits <= '0;
        dcnt  <= '0;
      end
      S_IDIV: begin
        rem   <= ge ? rem2 - dsor : rem2;
        qbits <= {qbits[QB-2:0], ge};
        num   <= num << 1;
        dcnt  <= dcnt + 6'd1;
      end
      S_I4: begin
        if (huge) val <= (nsgn != dsgn) ? -(WW'(1) << QB) : (WW'(1) << QB);
        else      val <= (nsgn != dsgn) ? -WW'(qbits) : WW'(qbits);
      end
      S_OUT: begin
        res[row] <= clipped;
        sat      <= sat | clip_hit;
        row      <= row + 2'd1;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_reg_valid <= 1'b0;
    end else begin
      if (out_reg_valid && out_ready) out_reg_valid <= 1'b0;
      if (state == S_DONE && (!out_reg_valid || out_ready)) out_reg_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_reg_valid || out_ready)) begin
      out_reg.out_a     <= res[0];
      out_reg.out_b     <= res[1];
      out_reg.out_c     <= res[2];
      out_reg.singular  <= sing;
      out_reg.saturated <= sat;
    end
  end

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_reg_valid) |-> $past(state == S_DONE))
    else $error("result shown without a finished item");

  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    (out_reg_valid && out_reg.singular) |->
      (out_reg.out_a == '0 && out_reg.out_b == '0 && out_reg.out_c == '0
       && !out_reg.saturated))
    else $error("singular result not cleared");

  a_divider_runs: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDIV && dcnt != 6'(QB - 1)) |=> (state == S_IDIV))
    else $error("divider left early");

endmodule
`default_nettype wire

@@ rtl/core/affine_cell_point_map.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// affine_cell_point_map: affine cell point map, forward and inverse
// Top level: configuration registers, input stage, job queue and back end.
// ----------------------------------------------------------------------------
// Load items (cmd 0) write one vertex and give no result; cmd 1 maps a
// reference point to physical space, cmd 2 maps a physical point back, each
// giving one result; cmd 3 is dropped. Items are taken one at a time by the
// back end, and a two-entry queue plus an input register let up to three
// items wait in front of it. A load is written to the vertex store as the back
// end takes it. Every product goes through one shared 32x33 multiplier in four
// passes (9 multiplies forward, 30 inverse), and each of the three inverse
// components then goes through a restoring divider, unless its quotient would
// overflow. The configuration registers may be written only while no item is
// in flight.
module affine_cell_point_map (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire afcpm_pkg::afcpm_in_t  in_item,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output afcpm_pkg::afcpm_out_t      out_item,
  input  wire logic                  cfg_wr_en,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [2:0]            cfg_data
);
  import afcpm_pkg::*;

  afcpm_cfg_t cfg;
  logic       fj_valid;
  logic       fj_ready;
  afcpm_job_t fj;
  logic       bj_valid;
  logic       bj_ready;
  afcpm_job_t bj;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.space_dim          <= 2'd3;
      cfg.axis_vertex_first  <= 3'd1;
      cfg.axis_vertex_second <= 3'd2;
      cfg.axis_vertex_third  <= 3'd3;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_SPACE_DIM: cfg.space_dim          <= cfg_data[1:0];
        CFG_AXIS_0:    cfg.axis_vertex_first  <= cfg_data;
        CFG_AXIS_1:    cfg.axis_vertex_second <= cfg_data;
        CFG_AXIS_2:    cfg.axis_vertex_third  <= cfg_data;
        default: ;
      endcase
    end
  end

  afcpm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .job_valid (fj_valid),
    .job_ready (fj_ready),
    .job       (fj)
  );

  afcpm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fj_valid),
    .push_ready (fj_ready),
    .push_job   (fj),
    .pop_valid  (bj_valid),
    .pop_ready  (bj_ready),
    .pop_job    (bj)
  );

  afcpm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job_valid (bj_valid),
    .job_ready (bj_ready),
    .job       (bj),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

@@ bench/affine_cell_point_map_test.sv @@
// ----------------------------------------------------------------------------
// affine_cell_point_map_test: self-checking bench for the affine point map
// Loads vertices, maps points forward and back under several register
// settings with random idling on both sides, and checks every result
// field by field against a fixed-point predictor kept in the bench.
// ----------------------------------------------------------------------------
module affine_cell_point_map_test;
  import afcpm_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE      = 64;

  typedef logic signed [255:0] wide_t;

  // Expected mapped points and the mirrored block state
  class point_map_scoreboard;
    afcpm_out_t expected_points[$];
    coord_t     vstore[VSLOTS][3];
    logic [1:0] dim_reg;
    logic [2:0] axis_reg[3];
    int         errors;
    int         checked;
    int         singular_seen;
    int         clipped_seen;

    function new();
      dim_reg     = 2'd3;
      axis_reg[0] = 3'd1;
      axis_reg[1] = 3'd2;
      axis_reg[2] = 3'd3;
      foreach (vstore[s, k]) vstore[s][k] = '0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [2:0] val);
      case (idx)
        CFG_SPACE_DIM: dim_reg = val[1:0];
        CFG_AXIS_0:    axis_reg[0] = val;
        CFG_AXIS_1:    axis_reg[1] = val;
        default:       axis_reg[2] = val;
      endcase
    endfunction

    function wide_t corner(int slot, int k, int d);
      if (k >= d) return '0;
      return wide_t'(vstore[slot][k]);
    endfunction

    function coord_t clip(wide_t v, inout bit sat);
      wide_t hi;
      wide_t lo;
      hi = wide_t'(64'sd2147483647);
      lo = -hi - 1;
      if (v > hi) begin
        sat = 1'b1;
        return coord_t'(hi);
      end
      if (v < lo) begin
        sat = 1'b1;
        return coord_t'(lo);
      end
      return coord_t'(v);
    endfunction

    // Work out the mapped point of one forward or inverse item
    function afcpm_out_t predict_mapped_point(afcpm_in_t it);
      afcpm_out_t o;
      wide_t      m[3][3];
      wide_t      a[3][3];
      wide_t      p[3];
      wide_t      v0[3];
      wide_t      rhs[3];
      wide_t      res[3];
      wide_t      acc;
      wide_t      mag;
      wide_t      det;
      wide_t      adet;
      coord_t     pin[3];
      bit         sat;
      int         d;
      pin[0] = it.coord_a;
      pin[1] = it.coord_b;
      pin[2] = it.coord_c;
      sat = 1'b0;
      d = (dim_reg == 2'd0) ? 1 : int'(dim_reg);
      for (int r = 0; r < 3; r++) begin
        p[r]  = (r >= d) ? '0 : wide_t'(pin[r]);
        v0[r] = corner(0, r, d);
        for (int c = 0; c < 3; c++) begin
          if (r < d && c < d) m[r][c] = corner(axis_reg[c], r, d) - corner(0, r, d);
          else m[r][c] = (r == c) ? wide_t'(65536) : '0;
        end
      end
      o.singular = 1'b0;
      if (it.cmd == CMD_FWD) begin
        for (int r = 0; r < 3; r++) begin
          acc = m[r][0] * p[0] + m[r][1] * p[1] + m[r][2] * p[2];
          mag = (acc < 0) ? -acc : acc;
          mag = (mag + 32768) >> 16;
          res[r] = ((acc < 0) ? -mag : mag) + v0[r];
        end
      end else begin
        a[0][0] = m[1][1] * m[2][2] - m[1][2] * m[2][1];
        a[0][1] = m[0][2] * m[2][1] - m[0][1] * m[2][2];
        a[0][2] = m[0][1] * m[1][2] - m[0][2] * m[1][1];
        a[1][0] = m[1][2] * m[2][0] - m[1][0] * m[2][2];
        a[1][1] = m[0][0] * m[2][2] - m[0][2] * m[2][0];
        a[1][2] = m[0][2] * m[1][0] - m[0][0] * m[1][2];
        a[2][0] = m[1][0] * m[2][1] - m[1][1] * m[2][0];
        a[2][1] = m[0][1] * m[2][0] - m[0][0] * m[2][1];
        a[2][2] = m[0][0] * m[1][1] - m[0][1] * m[1][0];
        det = m[0][0] * a[0][0] + m[0][1] * a[1][0] + m[0][2] * a[2][0];
        for (int r = 0; r < 3; r++) rhs[r] = p[r] - v0[r];
        if (det == 0) begin
          o.singular = 1'b1;
          for (int r = 0; r < 3; r++) res[r] = '0;
        end else begin
          adet = (det < 0) ? -det : det;
          for (int r = 0; r < 3; r++) begin
            acc = a[r][0] * rhs[0] + a[r][1] * rhs[1] + a[r][2] * rhs[2];
            mag = (acc < 0) ? -acc : acc;
            mag = ((mag << 17) + adet) / (adet << 1);
            res[r] = ((acc < 0) != (det < 0)) ? -mag : mag;
          end
        end
      end
      o.out_a = clip(res[0], sat);
      o.out_b = clip(res[1], sat);
      o.out_c = clip(res[2], sat);
      o.saturated = sat;
      return o;
    endfunction

    // Note an accepted item: update the store or queue its mapped point
    function void note_input(afcpm_in_t it);
      if (it.cmd == CMD_LOAD) begin
        vstore[it.vertex_slot][0] = it.coord_a;
        vstore[it.vertex_slot][1] = it.coord_b;
        vstore[it.vertex_slot][2] = it.coord_c;
      end else if (it.cmd != CMD_NONE) begin
        expected_points.push_back(predict_mapped_point(it));
      end
    endfunction

    function void report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("MISMATCH result %0d %s: got %h, want %h", checked, what, got, want);
    endfunction

    // Compare one result with the oldest expected point
    function void check(afcpm_out_t got);
      afcpm_out_t want;
      if (expected_points.size() == 0) begin
        errors++;
        $display("MISMATCH unexpected result %h", got);
        return;
      end
      want = expected_points.pop_front();
      if (got.out_a !== want.out_a) report("out_a", got.out_a, want.out_a);
      if (got.out_b !== want.out_b) report("out_b", got.out_b, want.out_b);
      if (got.out_c !== want.out_c) report("out_c", got.out_c, want.out_c);
      if (got.singular !== want.singular) report("singular", got.singular, want.singular);
      if (got.saturated !== want.saturated)
        report("saturated", got.saturated, want.saturated);
      singular_seen += want.singular;
      clipped_seen  += want.saturated;
      checked++;
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  afcpm_in_t  in_item = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  afcpm_out_t out_item;
  logic       cfg_wr_en = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [2:0] cfg_data = '0;

  point_map_scoreboard sb = new();
  bit calm = 1'b0;
  int cycles = 0;
  int items_sent = 0;

  affine_cell_point_map u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Take results and stall the output at random
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check(out_item);
    out_ready <= calm || ($urandom_range(0, 99) >= 6);
  end

  // Offer one item and hold it until accepted
  task automatic send_item(logic [1:0] cmd, logic [2:0] slot, coord_t a, coord_t b,
                           coord_t c);
    afcpm_in_t it;
    it.cmd = cmd;
    it.vertex_slot = slot;
    it.coord_a = a;
    it.coord_b = b;
    it.coord_c = c;
    if (!calm && $urandom_range(0, 99) < 6) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
    items_sent++;
  endtask

  // Drop valid and let the block drain before touching registers
  task automatic go_idle();
    in_valid <= 1'b0;
    while (sb.expected_points.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [2:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic apply_setting(logic [1:0] dim, logic [2:0] a0, logic [2:0] a1,
                               logic [2:0] a2);
    write_reg(CFG_SPACE_DIM, {1'b0, dim});
    write_reg(CFG_AXIS_0, a0);
    write_reg(CFG_AXIS_1, a1);
    write_reg(CFG_AXIS_2, a2);
  endtask

  // Mostly small coordinates, now and then any 32-bit value
  function automatic coord_t rand_coord();
    if ($urandom_range(0, 7) == 0) return coord_t'($urandom);
    return coord_t'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
  endfunction

  task automatic random_burst(int n);
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 14)
        send_item(CMD_LOAD, 3'($urandom), rand_coord(), rand_coord(), rand_coord());
      else if (pick < 17)
        send_item(CMD_NONE, 3'($urandom), coord_t'($urandom), coord_t'($urandom),
                  coord_t'($urandom));
      else
        send_item(pick < 55 ? CMD_FWD : CMD_INV, 3'($urandom), rand_coord(),
                  rand_coord(), rand_coord());
    end
  endtask

  localparam coord_t MAXC = 32'sh7fffffff;
  localparam coord_t MINC = 32'sh80000000;

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Fill every slot, then the directed cases under the reset setting
    apply_setting(2'd3, 3'd1, 3'd2, 3'd3);
    send_item(CMD_LOAD, 3'd0, 32'sh10000, 32'sh20000, -32'sh10000);
    send_item(CMD_LOAD, 3'd1, 32'sh30000, 32'sh20000, -32'sh10000);
    send_item(CMD_LOAD, 3'd2, 32'sh10000, 32'sh50000, -32'sh8000);
    send_item(CMD_LOAD, 3'd3, 32'sh20000, 32'sh30000, 32'sh30000);
    send_item(CMD_LOAD, 3'd4, MAXC, MINC, 32'sh0);
    send_item(CMD_LOAD, 3'd5, MINC, MAXC, -32'sh1);
    send_item(CMD_LOAD, 3'd6, 32'sh12345, -32'sh54321, 32'sh777);
    send_item(CMD_LOAD, 3'd7, 32'sh0, 32'sh0, 32'sh0);
    send_item(CMD_FWD, 3'd0, 32'sh8000, 32'sh4000, 32'sh2000);
    send_item(CMD_FWD, 3'd0, MAXC, MINC, MAXC);
    send_item(CMD_FWD, 3'd7, MINC, MINC, MINC);
    send_item(CMD_INV, 3'd0, 32'sh28000, 32'sh31000, -32'sh4000);
    send_item(CMD_INV, 3'd5, MAXC, MINC, MAXC);
    send_item(CMD_INV, 3'd0, 32'sh0, 32'sh0, 32'sh0);
    send_item(CMD_NONE, 3'd7, MAXC, MINC, 32'sh1);
    // A collapsed column makes the Jacobian singular
    send_item(CMD_LOAD, 3'd3, 32'sh10000, 32'sh20000, -32'sh10000);
    send_item(CMD_INV, 3'd0, 32'sh5000, 32'sh6000, 32'sh7000);
    send_item(CMD_FWD, 3'd0, 32'sh5000, 32'sh6000, 32'sh7000);
    send_item(CMD_LOAD, 3'd3, 32'sh20000, 32'sh30000, 32'sh30000);
    send_item(CMD_INV, 3'd0, 32'sh1, -32'sh1, 32'sh1);
    random_burst(40);
    go_idle();

    // Sweep register settings, extremes among them
    apply_setting(2'd2, 3'd1, 3'd2, 3'd7);
    random_burst(50);
    go_idle();
    calm = 1'b1;
    apply_setting(2'd1, 3'd6, 3'd0, 3'd0);
    random_burst(50);
    go_idle();
    calm = 1'b0;
    apply_setting(2'd0, 3'd4, 3'd5, 3'd6);
    random_burst(40);
    go_idle();
    apply_setting(2'd3, 3'd7, 3'd0, 3'd5);
    random_burst(40);
    go_idle();
    apply_setting(2'd3, 3'd0, 3'd0, 3'd0);
    random_burst(30);
    go_idle();
    apply_setting(2'd3, 3'd4, 3'd5, 3'd6);
    random_burst(40);
    go_idle();
    for (int k = 0; k < 3; k++) begin
      apply_setting(2'($urandom_range(0, 3)), 3'($urandom), 3'($urandom), 3'($urandom));
      random_burst(50);
      go_idle();
    end

    $display("sent %0d items, checked %0d mapped points", items_sent, sb.checked);
    $display("singular results %0d, clipped results %0d", sb.singular_seen,
             sb.clipped_seen);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
